// ===== design/ethny_pkg.sv =====
// package for the ethiopian new-year day offset block
// holds field widths, month tables and the century offset helper
// no dependencies
package ethny_pkg;

    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int DAYS_W   = 10;
    localparam int YLEN_W   = 9;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 24;
    localparam int QUOT_W   = 8;
    localparam int SUM_W    = 12;

    // reciprocal for year / 100, exact for every 14-bit year
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 19;
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

    localparam logic [MONTH_W-1:0] MONTH_LAST = 4'd13;
    localparam logic [YEAR_W-1:0]  YEAR_SWITCH = 14'd1752;
    localparam logic [QUOT_W-1:0]  CENT_FIRST  = 8'd18;
    localparam logic [YLEN_W-1:0]  YLEN_BASE   = 9'd365;

    typedef logic signed [SUM_W-1:0] t_sum;

    // days from january 1 to the first of month m, common year, for months 1 to 9; other months give 0
    function automatic logic [8:0] month_prefix(input logic [MONTH_W-1:0] m);
        logic [8:0] v;
        unique case (m)
            4'd2:    v = 9'd31;
            4'd3:    v = 9'd59;
            4'd4:    v = 9'd90;
            4'd5:    v = 9'd120;
            4'd6:    v = 9'd151;
            4'd7:    v = 9'd181;
            4'd8:    v = 9'd212;
            4'd9:    v = 9'd243;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    // days from august 1 to the first of month m (month 13 closes the year)
    function automatic logic [8:0] from_aug(input logic [MONTH_W-1:0] m);
        logic [8:0] v;
        unique case (m)
            4'd9:    v = 9'd31;
            4'd10:   v = 9'd61;
            4'd11:   v = 9'd92;
            4'd12:   v = 9'd122;
            4'd13:   v = 9'd153;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    // days from september 1 to the first of month m
    function automatic logic [8:0] from_sep(input logic [MONTH_W-1:0] m);
        logic [8:0] v;
        unique case (m)
            4'd10:   v = 9'd30;
            4'd11:   v = 9'd61;
            4'd12:   v = 9'd91;
            4'd13:   v = 9'd122;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    // century offset from the year's hundreds q
    function automatic logic signed [8:0] cent_offset(input logic [QUOT_W-1:0] q);
        logic signed [8:0] v;
        if (q < CENT_FIRST) begin
            v = 9'sd2;
        end else begin
            v = 9'sd15 - signed'({1'b0, q}) + signed'({3'b0, q[QUOT_W-1:2]});
        end
        return v;
    endfunction

    function automatic t_sum ext9(input logic [8:0] v);
        return signed'({{(SUM_W-9){1'b0}}, v});
    endfunction

endpackage

// ===== design/ethiopian_new_year_day_offset.sv =====
// channel    dir  tdata fields (lowest bit up)
// s request  in   month_number[3:0], year_number[17:4], zero pad to 24
// m result   out  days_since_new_year[9:0], ethiopian_year_length[18:10], zero pad
//
// one request per cycle while the result register is not stalled
// input register, then one pass of calendar logic into the result register
// the year / 100 reciprocal multiply is the longest path
// reset clears both valid flags; a stalled result holds and the input
// register keeps taking requests while the result register can drain
//
// top level of the ethiopian new-year day offset block, uses ethny_pkg
module ethiopian_new_year_day_offset (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // month_number[3:0], year_number[17:4]
    input  logic [ethny_pkg::S_DATA_W-1:0] i_s_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // days_since_new_year[9:0], ethiopian_year_length[18:10]
    output logic [ethny_pkg::M_DATA_W-1:0] o_m_tdata
);
    import ethny_pkg::*;

    logic                   r_in_valid;
    logic [MONTH_W-1:0]     r_month;
    logic [YEAR_W-1:0]      r_year;
    logic                   r_out_valid;
    logic [DAYS_W-1:0]      r_days;
    logic [YLEN_W-1:0]      r_ylen;

    logic                   w_out_load;
    logic                   w_in_load;
    logic [MONTH_W-1:0]     w_m;
    logic [YEAR_W+RECIP_W-1:0] w_prod;
    logic [QUOT_W-1:0]      w_q;
    logic [QUOT_W-1:0]      w_q_prev;
    logic [YEAR_W:0]        w_q100;
    logic                   w_cent;
    logic                   w_jul;
    logic                   w_jleap;
    logic                   w_gleap;
    logic                   w_leap;
    logic                   w_late;
    t_sum                   w_nyd;
    t_sum                   w_base;
    t_sum                   w_days;
    logic                   w_len_jul;
    logic                   w_inc;
    logic [1:0]             w_ymod;
    logic [DAYS_W-1:0]      n_days;
    logic [YLEN_W-1:0]      n_ylen;

    assign w_out_load = r_in_valid && (!r_out_valid || i_m_tready);
    assign w_in_load  = !r_in_valid || w_out_load;
    assign o_s_tready = w_in_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_load) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_load && i_s_tvalid) begin
            r_month <= i_s_tdata[MONTH_W-1:0];
            r_year  <= i_s_tdata[MONTH_W+YEAR_W-1:MONTH_W];
        end
    end

    always_comb begin
        w_m = (r_month > MONTH_LAST) ? MONTH_LAST : r_month;

        // hundreds of the year and whether it is a whole century
        w_prod   = {{RECIP_W{1'b0}}, r_year} * {{YEAR_W{1'b0}}, RECIP_100};
        w_q      = w_prod[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
        w_q100   = {1'b0, w_q, 6'b0} + {2'b0, w_q, 5'b0} + {5'b0, w_q, 2'b0};
        w_cent   = (w_q100 == {1'b0, r_year});
        w_q_prev = w_q - {{(QUOT_W-1){1'b0}}, w_cent};

        w_jul   = (r_year < YEAR_SWITCH) || ((r_year == YEAR_SWITCH) && (w_m <= 4'd9));
        w_jleap = (r_year[1:0] == 2'd0) && (r_year != 14'd4);
        w_gleap = ((r_year[1:0] == 2'd0) && !w_cent) || (w_cent && (w_q[1:0] == 2'd0));
        w_leap  = w_jul ? w_jleap : w_gleap;
        w_late  = w_jul ? (w_m > 4'd8) : (w_m > 4'd9);

        // the previous year's new year depends on (y - 1) mod 4 == 3, i.e. y mod 4 == 0
        if (w_jul) begin
            if (w_late) begin
                w_nyd  = (r_year[1:0] == 2'd3) ? 12'sd30 : 12'sd29;
                w_base = 12'sd2 - w_nyd + ext9(from_aug(w_m))
                         + ((r_year < 14'd4) ? 12'sd1 : 12'sd0);
            end else begin
                w_nyd  = (r_year[1:0] == 2'd0) ? 12'sd30 : 12'sd29;
                w_base = 12'sd2 - w_nyd + ext9(from_aug(MONTH_LAST))
                         + ((r_year < 14'd5) ? 12'sd1 : 12'sd0);
            end
        end else begin
            if (w_late) begin
                w_nyd  = (r_year[1:0] == 2'd3) ? 12'sd12 : 12'sd11;
                w_base = 12'sd2 - w_nyd + ext9(from_sep(w_m))
                         + t_sum'(cent_offset(w_q));
            end else begin
                w_nyd  = (r_year[1:0] == 2'd0) ? 12'sd12 : 12'sd11;
                w_base = 12'sd2 - w_nyd + ext9(from_sep(MONTH_LAST))
                         + t_sum'(cent_offset(w_q_prev));
            end
        end

        if (w_late) begin
            w_days = w_base;
        end else begin
            w_days = w_base + ext9(month_prefix(w_m))
                     + ((w_leap && (w_m >= 4'd3)) ? 12'sd1 : 12'sd0);
        end
        n_days = w_days[DAYS_W-1:0];

        // ethiopian year length follows the western start year
        w_len_jul = (r_year < YEAR_SWITCH) || ((r_year == YEAR_SWITCH) && (w_m <= 4'd8));
        w_inc     = w_len_jul ? (w_m > 4'd8) : (w_m > 4'd9);
        w_ymod    = r_year[1:0] + {1'b0, w_inc};
        n_ylen    = YLEN_BASE + {{(YLEN_W-1){1'b0}}, (w_ymod == 2'd3)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_days <= n_days;
            r_ylen <= n_ylen;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_DATA_W-DAYS_W-YLEN_W){1'b0}}, r_ylen, r_days};

endmodule

// ===== design/ethny_checker.sv =====
// port-level checks for the ethiopian new-year day offset block
// bound to the top level, uses ethny_pkg
module ethny_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic [ethny_pkg::S_DATA_W-1:0] i_s_tdata,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [ethny_pkg::M_DATA_W-1:0] o_m_tdata
);
    import ethny_pkg::*;

    // no result straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    // requests are refused only while a result is waiting
    a_ready_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid && !i_m_tready)
        else $error("request refused with free result slot");

    // year length is 365 or 366 and padding is zero
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[DAYS_W+YLEN_W-1:DAYS_W] == 9'd365
                        || o_m_tdata[DAYS_W+YLEN_W-1:DAYS_W] == 9'd366)
                       && (o_m_tdata[M_DATA_W-1:DAYS_W+YLEN_W] == '0))
        else $error("bad year length field");

endmodule

bind ethiopian_new_year_day_offset ethny_checker u_ethny_checker (.*);

// ===== tb/sv/ethny_offset_checker.sv =====
`timescale 1ns / 100ps
// checker for the ethiopian new-year day offset block: watches both stream channels,
// predicts each result from the request and compares field by field
// depends on ethny_pkg for the field widths
module ethny_offset_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    // month_number[3:0], year_number[17:4]
    input  logic [ethny_pkg::S_DATA_W-1:0] i_s_tdata,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    // days_since_new_year[9:0], ethiopian_year_length[18:10]
    input  logic [ethny_pkg::M_DATA_W-1:0] i_m_tdata,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_results
);
    import ethny_pkg::*;

    localparam int SWITCH_YEAR = 1752;
    localparam int LAST_MONTH  = 13;
    localparam int PAD_W       = M_DATA_W - DAYS_W - YLEN_W;

    typedef struct packed {
        logic [DAYS_W-1:0]  days;
        logic [YLEN_W-1:0]  ylen;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } t_offset_exp;

    t_offset_exp expected_offsets[$];
    t_offset_exp head;

    // zero-based month index, common year
    function automatic int month_len(input int idx);
        case (idx)
            1:           return 28;
            3, 5, 8, 10: return 30;
            default:     return 31;
        endcase
    endfunction

    // days of months lo .. hi-1, never past december
    function automatic int months_span(input int lo, input int hi, input int feb_extra);
        int total = 0;
        for (int i = lo; i < hi && i < 12; i++) begin
            if (i >= 0) begin
                total += month_len(i) + ((i == 1) ? feb_extra : 0);
            end
        end
        return total;
    endfunction

    // mathematical mod 4, also for negative years
    function automatic int mod_four(input int v);
        return v & 3;
    endfunction

    function automatic int julian_leap(input int y);
        return (mod_four(y) == 0 && y != 4 && y <= SWITCH_YEAR) ? 1 : 0;
    endfunction

    function automatic int gregorian_leap(input int y);
        return (((mod_four(y) == 0 && (y % 100) != 0) || (y % 400) == 0)
                && y > SWITCH_YEAR) ? 1 : 0;
    endfunction

    function automatic int century_shift(input int y);
        int c = (y + 100) / 100;
        if (y < 0 || c <= 18) begin
            return 2;
        end
        return 2 - (c - 18) + ((c - 1) / 4 - 4);
    endfunction

    // count from new year for months already past it
    function automatic int julian_from_new_year(input int m, input int y);
        int nyd = (mod_four(y) == 3) ? 30 : 29;
        return 2 - nyd + months_span(7, m - 1, 0) + ((y < 4) ? 1 : 0);
    endfunction

    function automatic int gregorian_from_new_year(input int m, input int y);
        int nyd = (mod_four(y) == 3) ? 12 : 11;
        return 2 - nyd + months_span(8, m - 1, 0) + century_shift(y);
    endfunction

    function automatic int new_year_offset(input int m, input int y);
        if (y < SWITCH_YEAR || (y == SWITCH_YEAR && m <= 9)) begin
            if (m > 8) begin
                return julian_from_new_year(m, y);
            end
            return julian_from_new_year(LAST_MONTH, y - 1) + months_span(0, m - 1, julian_leap(y));
        end
        if (m > 9) begin
            return gregorian_from_new_year(m, y);
        end
        // previous year always closes on the gregorian side here
        return gregorian_from_new_year(LAST_MONTH, y - 1)
               + months_span(0, m - 1, gregorian_leap(y));
    endfunction

    function automatic int ethiopian_year_days(input int m, input int y);
        int start_year = y;
        if (y < SWITCH_YEAR || (y == SWITCH_YEAR && m <= 8)) begin
            start_year += (m > 8) ? 1 : 0;
        end else begin
            start_year += (m > 9) ? 1 : 0;
        end
        return 365 + ((mod_four(start_year) == 3) ? 1 : 0);
    endfunction

    function automatic t_offset_exp predict_new_year_offset(input logic [MONTH_W-1:0] month,
                                                           input logic [YEAR_W-1:0] year);
        t_offset_exp e;
        int m = int'(month);
        int y = int'(year);
        int d;
        int len;
        if (m > LAST_MONTH) begin
            m = LAST_MONTH;
        end
        d      = new_year_offset(m, y);
        len    = ethiopian_year_days(m, y);
        e.days  = d[DAYS_W-1:0];
        e.ylen  = len[YLEN_W-1:0];
        e.month = month;
        e.year  = year;
        return e;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want,
                                   input t_offset_exp e);
        $display("%0t mismatch %s: got %0d want %0d (month %0d year %0d)",
                 $realtime, what, got, want, e.month, e.year);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_results    = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) begin
                expected_offsets.push_back(predict_new_year_offset(i_s_tdata[MONTH_W-1:0],
                                                                   i_s_tdata[MONTH_W +: YEAR_W]));
            end
            if (i_m_tvalid && i_m_tready) begin
                o_results++;
                if (expected_offsets.size() == 0) begin
                    head = '0;
                    report_mismatch("result with no request pending", 0, 0, head);
                end else begin
                    head = expected_offsets.pop_front();
                    if (i_m_tdata[DAYS_W-1:0] !== head.days) begin
                        report_mismatch("days_since_new_year",
                                        int'($signed(i_m_tdata[DAYS_W-1:0])),
                                        int'($signed(head.days)), head);
                    end
                    if (i_m_tdata[DAYS_W +: YLEN_W] !== head.ylen) begin
                        report_mismatch("ethiopian_year_length",
                                        int'(i_m_tdata[DAYS_W +: YLEN_W]), int'(head.ylen), head);
                    end
                    if (i_m_tdata[M_DATA_W-1 -: PAD_W] !== '0) begin
                        report_mismatch("padding bits", int'(i_m_tdata[M_DATA_W-1 -: PAD_W]),
                                        0, head);
                    end
                end
            end
            o_pending = expected_offsets.size();
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// top of the testbench for the ethiopian new-year day offset block
// drives requests and result backpressure, the checker beside the block does the comparing
// depends on ethny_pkg, ethiopian_new_year_day_offset and ethny_offset_checker
module tb_top;
    import ethny_pkg::*;

    localparam int RANDOM_ITEMS = 1125;
    localparam int CALM_TAIL    = 150;
    localparam int STALL_LIMIT  = 500;
    localparam int DRAIN_CYCLES = 8;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata = '0;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [M_DATA_W-1:0] o_m_tdata;

    int fail_count;
    int pending;
    int results;
    int sent = 0;
    int directed_sent = 0;
    int quiet_cycles = 0;
    int stall_left = 0;
    bit idle_on = 1'b1;
    bit run_done = 1'b0;

    always #5 i_clk = ~i_clk;

    ethiopian_new_year_day_offset dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    ethny_offset_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results)
    );

    // result side backpressure in bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(1, 6) - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || run_done || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no traffic for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending);
            $display("tb_top NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic push_request(input logic [MONTH_W-1:0] month, input logic [YEAR_W-1:0] year);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_s_tvalid = 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = {{(S_DATA_W-MONTH_W-YEAR_W){1'b0}}, year, month};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [YEAR_W-1:0] pick_year();
        int sel = $urandom_range(0, 9);
        int y;
        case (sel)
            0, 1:    y = $urandom_range(1745, 1760);
            2, 3, 4: y = $urandom_range(1, 3000);
            5, 6:    y = $urandom_range(1, 9999);
            7:       y = $urandom_range(0, 16383);
            8:       y = $urandom_range(0, 15);
            default: y = $urandom_range(0, 163) * 100 + $urandom_range(0, 4);
        endcase
        return y[YEAR_W-1:0];
    endfunction

    initial begin
        logic [MONTH_W-1:0] month;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // field extremes, both eras, the 1752 switch, early julian years, century years
        push_request(4'd0,  14'd0);
        push_request(4'd15, 14'd16383);
        push_request(4'd1,  14'd1);
        push_request(4'd13, 14'd3);
        push_request(4'd9,  14'd3);
        push_request(4'd12, 14'd4);
        push_request(4'd1,  14'd4);
        push_request(4'd3,  14'd4);
        push_request(4'd2,  14'd8);
        push_request(4'd8,  14'd1752);
        push_request(4'd9,  14'd1752);
        push_request(4'd10, 14'd1752);
        push_request(4'd12, 14'd1752);
        push_request(4'd1,  14'd1753);
        push_request(4'd2,  14'd1800);
        push_request(4'd3,  14'd1900);
        push_request(4'd2,  14'd2000);
        push_request(4'd14, 14'd2100);
        push_request(4'd9,  14'd2023);
        push_request(4'd10, 14'd2023);
        push_request(4'd11, 14'd9999);
        push_request(4'd5,  14'd9999);
        push_request(4'd6,  14'd12000);
        push_request(4'd7,  14'd8191);
        push_request(4'd4,  14'd8192);
        directed_sent = sent;

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 64 == 0) begin
                idle_on = ($urandom_range(0, 3) != 0);
            end
            if (n >= RANDOM_ITEMS - CALM_TAIL) begin
                idle_on = 1'b0;
            end
            if ($urandom_range(0, 9) == 0) begin
                month = MONTH_W'($urandom_range(0, 15));
            end else begin
                month = MONTH_W'($urandom_range(1, 12));
            end
            push_request(month, pick_year());
        end
        i_s_tvalid = 1'b0;

        while (pending != 0) @(negedge i_clk);
        run_done = 1'b1;
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("covered %0d requests (%0d directed, %0d random), %0d results checked",
                 sent, directed_sent, sent - directed_sent, results);
        $display("months 0 to 15, years 0 to 16383, julian and gregorian eras, random backpressure");
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
